FILE: sv/assert_macros.svh
// Assertion helpers, clocked and reset-gated.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/stg_pkg.sv
package stg_pkg;

    localparam int ID_W      = 6;
    localparam int ENTRIES   = 1 << ID_W;
    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 48;
    localparam int DIFF_W    = VAL_W + 1;
    localparam int SPAN_W    = 47;
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int FUNC_W    = 2;
    localparam int SCALE_SH  = 7;                  // |d| > thr/128  <=>  |d|*128 > thr
    localparam int CMP_W     = DIFF_W + SCALE_SH + 1;
    localparam int ENT_W     = TIME_W + VAL_W;     // {last_time, prev_value}

    localparam logic [CFG_W-1:0] OVERRIDE_RST = CFG_W'(50);

    // MIDI threshold of 3.0, already scaled by 128
    localparam logic [DIFF_W-1:0] MIDI_THR = DIFF_W'(3) << (FRAC_BITS + SCALE_SH);

    localparam logic [FUNC_W-1:0] FN_ENABLE  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_DISABLE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_MOVE    = 2'd2;

    typedef struct packed {
        logic far_new;
        logic far_prev;
        logic same;
        logic late;
    } stg_cond_t;

endpackage

FILE: sv/stg_ram.sv
module stg_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 80,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/stg_eval.sv
module stg_eval (
    input  logic                               clk,
    input  logic                               load,
    input  logic signed [stg_pkg::VAL_W-1:0]   cur_value,
    input  logic signed [stg_pkg::VAL_W-1:0]   new_value,
    input  logic        [stg_pkg::VAL_W-1:0]   prev_value,
    input  logic                               prev_ok,
    input  logic        [stg_pkg::TIME_W-1:0]  now_ms,
    input  logic        [stg_pkg::TIME_W-1:0]  last_time,
    input  logic                               is_midi,
    input  logic        [stg_pkg::SPAN_W-1:0]  span,
    input  logic        [stg_pkg::CFG_W-1:0]   override_ms,
    output stg_pkg::stg_cond_t                 cond
);

    logic signed [stg_pkg::DIFF_W-1:0] cur_x;
    logic signed [stg_pkg::DIFF_W-1:0] new_x;
    logic signed [stg_pkg::DIFF_W-1:0] prev_x;
    logic        [stg_pkg::DIFF_W-1:0] span3;

    logic signed [stg_pkg::DIFF_W-1:0] diff_reg;
    logic signed [stg_pkg::DIFF_W-1:0] pdiff_reg;
    logic        [stg_pkg::DIFF_W-1:0] thr_reg;
    logic        [stg_pkg::TIME_W-1:0] elapsed_reg;

    function automatic logic is_far(input logic signed [stg_pkg::DIFF_W-1:0] d,
                                    input logic [stg_pkg::DIFF_W-1:0] thr);
        logic signed [stg_pkg::CMP_W-1:0] ds;
        logic signed [stg_pkg::CMP_W-1:0] ts;
        logic signed [stg_pkg::CMP_W-1:0] sum;
        ds  = {{(stg_pkg::CMP_W-stg_pkg::DIFF_W){d[stg_pkg::DIFF_W-1]}}, d}
              <<< stg_pkg::SCALE_SH;
        ts  = $signed({{(stg_pkg::CMP_W-stg_pkg::DIFF_W){1'b0}}, thr});
        sum = ds + ts;
        // far above: d*128 > thr; far below: d*128 < -thr
        return (ds > ts) || sum[stg_pkg::CMP_W-1];
    endfunction

    assign cur_x  = {cur_value[stg_pkg::VAL_W-1], cur_value};
    assign new_x  = {new_value[stg_pkg::VAL_W-1], new_value};
    assign prev_x = $signed({prev_value[stg_pkg::VAL_W-1], prev_value});
    assign span3  = {2'b00, span} + {1'b0, span, 1'b0};

    // first step: differences, threshold, elapsed time
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            diff_reg    <= cur_x - new_x;
            pdiff_reg   <= prev_ok ? (cur_x - prev_x) : '0;
            thr_reg     <= is_midi ? stg_pkg::MIDI_THR : span3;
            elapsed_reg <= now_ms - last_time;
        end
    end

    // second step: compares
    always_comb
    begin
        cond.far_new  = is_far(diff_reg, thr_reg);
        cond.far_prev = is_far(pdiff_reg, thr_reg);
        cond.same     = (diff_reg[stg_pkg::DIFF_W-1] && pdiff_reg[stg_pkg::DIFF_W-1])
                     || (!diff_reg[stg_pkg::DIFF_W-1] && (diff_reg != '0)
                         && !pdiff_reg[stg_pkg::DIFF_W-1] && (pdiff_reg != '0));
        cond.late     = elapsed_reg > {{(stg_pkg::TIME_W-stg_pkg::CFG_W){1'b0}}, override_ms};
    end

endmodule

FILE: sv/soft_takeover_gate_top.sv
// Soft-takeover gate for a control surface, one entry per control.
// Input channel (in_valid / in_stall) carries one event per transfer: func
// (enable, disable or move), control_id, now_ms, current_value, new_value,
// is_midi and span. The output channel (out_valid / out_stall) returns one
// transfer per event carrying ignored, which is 1 only for a move that must
// be dropped.
// The input transfer captures the event and reads its entry, the difference
// step registers the differences, and the compare step writes back the entry
// and loads the output register. The next event is taken only once that
// write-back is done, so events do not overlap in the state memory.
// The output register lets a new event enter while the previous result still
// waits; a stalled result holds the block in its final step until it leaves.
// cfg_we / cfg_wdata write override_ms; write only while the block is idle.
// Reset clears the valid bits of every entry and sets override_ms to 50; the
// time and previous-value memory needs no clearing, as the valid bits guard it.
module soft_takeover_gate_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic        [stg_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic        [stg_pkg::FUNC_W-1:0]  func,
    input  logic        [stg_pkg::ID_W-1:0]    control_id,
    input  logic        [stg_pkg::TIME_W-1:0]  now_ms,
    input  logic signed [stg_pkg::VAL_W-1:0]   current_value,
    input  logic signed [stg_pkg::VAL_W-1:0]   new_value,
    input  logic                               is_midi,
    input  logic        [stg_pkg::SPAN_W-1:0]  span,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               ignored
);

`include "assert_macros.svh"

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIFF = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;

    logic [1:0] state_reg, state_next;

    logic [stg_pkg::CFG_W-1:0] override_reg;

    // held event
    logic        [stg_pkg::FUNC_W-1:0] func_reg;
    logic        [stg_pkg::ID_W-1:0]   id_reg;
    logic        [stg_pkg::TIME_W-1:0] now_reg;
    logic signed [stg_pkg::VAL_W-1:0]  cur_reg;
    logic signed [stg_pkg::VAL_W-1:0]  new_reg;
    logic                              midi_reg;
    logic        [stg_pkg::SPAN_W-1:0] span_reg;

    logic [stg_pkg::ENTRIES-1:0] timed_valid_reg, timed_valid_next;
    logic [stg_pkg::ENTRIES-1:0] prev_valid_reg, prev_valid_next;

    logic out_valid_reg, out_valid_next;
    logic ignored_reg;

    logic                        in_xfer;
    logic                        cmp_done;
    logic                        tv;
    logic                        pv;
    logic                        ign;
    logic                        ram_we;
    logic [stg_pkg::ENT_W-1:0]   ram_wdata;
    logic [stg_pkg::ENT_W-1:0]   ram_rdata;
    logic [stg_pkg::TIME_W-1:0]  old_time;
    logic [stg_pkg::VAL_W-1:0]   old_prev;
    stg_pkg::stg_cond_t          cond;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign ignored   = ignored_reg;

    // leave the final step only when the output register is free or emptying
    assign cmp_done = (state_reg == S_CMP) && (!out_valid_reg || !out_stall);

    assign tv       = timed_valid_reg[id_reg];
    assign pv       = prev_valid_reg[id_reg];
    assign old_time = ram_rdata[stg_pkg::ENT_W-1 -: stg_pkg::TIME_W];
    assign old_prev = ram_rdata[stg_pkg::VAL_W-1:0];

    assign ign = (func_reg == stg_pkg::FN_MOVE) && tv && cond.far_new && cond.far_prev
              && cond.same && cond.late;

    stg_ram #(
        .DEPTH (stg_pkg::ENTRIES),
        .WIDTH (stg_pkg::ENT_W),
        .AW    (stg_pkg::ID_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (id_reg),
        .wdata (ram_wdata),
        .re    (in_xfer),
        .raddr (control_id),
        .rdata (ram_rdata)
    );

    stg_eval u_eval (
        .clk         (clk),
        .load        (state_reg == S_DIFF),
        .cur_value   (cur_reg),
        .new_value   (new_reg),
        .prev_value  (old_prev),
        .prev_ok     (pv),
        .now_ms      (now_reg),
        .last_time   (old_time),
        .is_midi     (midi_reg),
        .span        (span_reg),
        .override_ms (override_reg),
        .cond        (cond)
    );

    // sequencing: idle -> difference step -> compare and write-back
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (cmp_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // write-back of the entry and its valid bits
    always_comb
    begin
        timed_valid_next = timed_valid_reg;
        prev_valid_next  = prev_valid_reg;
        ram_we           = 1'b0;
        ram_wdata        = {now_reg, new_reg};
        if (cmp_done)
        begin
            case (func_reg)
                stg_pkg::FN_ENABLE:
                begin
                    // keep an existing timestamp and previous value
                    ram_we                   = 1'b1;
                    ram_wdata                = {(tv ? old_time : now_reg),
                                                (pv ? old_prev : cur_reg)};
                    timed_valid_next[id_reg] = 1'b1;
                    prev_valid_next[id_reg]  = 1'b1;
                end
                stg_pkg::FN_DISABLE:
                begin
                    timed_valid_next[id_reg] = 1'b0;
                end
                stg_pkg::FN_MOVE:
                begin
                    // an accepted move refreshes the timestamp; any move on an enabled control sets prev
                    if (tv)
                    begin
                        ram_we                  = 1'b1;
                        ram_wdata               = {(ign ? old_time : now_reg), new_reg};
                        prev_valid_next[id_reg] = 1'b1;
                    end
                end
                default:
                begin
                    ram_we = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmp_done)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            override_reg    <= stg_pkg::OVERRIDE_RST;
            timed_valid_reg <= '0;
            prev_valid_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            timed_valid_reg <= timed_valid_next;
            prev_valid_reg  <= prev_valid_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_we)
            begin
                override_reg <= cfg_wdata;
            end
        end
    end

    // payload: capture on input transfer, result on completion
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            func_reg <= func;
            id_reg   <= control_id;
            now_reg  <= now_ms;
            cur_reg  <= current_value;
            new_reg  <= new_value;
            midi_reg <= is_midi;
            span_reg <= span;
        end
        if (cmp_done)
        begin
            ignored_reg <= ign;
        end
    end

    `ASSERT_IMPL(a_we_in_cmp, clk, rst_n, ram_we, cmp_done)
    `ASSERT_IMPL(a_ign_move_only, clk, rst_n, cmp_done && ign, (func_reg == stg_pkg::FN_MOVE) && tv)
    `ASSERT_NEXT(a_disable_clears, clk, rst_n, cmp_done && (func_reg == stg_pkg::FN_DISABLE), !timed_valid_reg[$past(id_reg)])
    `ASSERT_NEXT(a_xfer_to_diff, clk, rst_n, in_xfer, state_reg == S_DIFF)

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

// Soft-takeover gate bench: a queue of events feeds a bursty driver, a monitor
// predicts each verdict at the moment its event transfers, and a stalling
// receiver checks the results in order.
module testbench;
    import stg_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 12;
    localparam int PHASE_EVENTS   = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 20;

    // func code that the block does not use; it must answer 0 and change nothing
    localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 48'sh8000_0000_0000;
    localparam logic signed [VAL_W-1:0] UNIT    = 48'sd1 << FRAC_BITS;
    localparam logic [SPAN_W-1:0]       SPAN_NOMINAL = SPAN_W'(10000000) << FRAC_BITS;
    localparam logic [TIME_W-1:0]       T0 = 32'hFFFF_FFC0;

    typedef struct {
        logic [FUNC_W-1:0]       op;
        logic [ID_W-1:0]         ctl;
        logic [TIME_W-1:0]       stamp;
        logic signed [VAL_W-1:0] cur;
        logic signed [VAL_W-1:0] want;
        logic                    midi;
        logic [SPAN_W-1:0]       spn;
    } gate_event_t;

    logic                      clk;
    logic                      rst_n         = 1'b0;
    logic                      cfg_we        = 1'b0;
    logic [CFG_W-1:0]          cfg_wdata     = '0;
    logic                      in_valid      = 1'b0;
    logic                      in_stall;
    logic [FUNC_W-1:0]         func          = '0;
    logic [ID_W-1:0]           control_id    = '0;
    logic [TIME_W-1:0]         now_ms        = '0;
    logic signed [VAL_W-1:0]   current_value = '0;
    logic signed [VAL_W-1:0]   new_value     = '0;
    logic                      is_midi       = 1'b0;
    logic [SPAN_W-1:0]         span          = '0;
    logic                      out_valid;
    logic                      out_stall     = 1'b0;
    logic                      ignored;

    // Mirror of the per-control table and the hold-off register
    bit                      armed     [ENTRIES];
    bit [TIME_W-1:0]         last_pass [ENTRIES];
    bit                      held      [ENTRIES];
    bit signed [VAL_W-1:0]   held_val  [ENTRIES];
    bit [CFG_W-1:0]          hold_off = OVERRIDE_RST;

    // Generator state: a resting value and a direction of travel per control
    bit signed [VAL_W-1:0]   anchor [ENTRIES];
    bit                      rising [ENTRIES];
    bit [TIME_W-1:0]         sim_clock = 32'hFFFF_0000;

    gate_event_t event_q[$];
    bit          verdict_q[$];

    bit in_xfer;
    int burst_left;
    int gap_left;
    int stall_mode;
    int stall_run;
    int idle_cycles;
    int fail_count;
    int events_sent;
    int moves_sent;
    int verdicts_checked;
    int drops_seen;
    int settings_run;

    soft_takeover_gate_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .control_id    (control_id),
        .now_ms        (now_ms),
        .current_value (current_value),
        .new_value     (new_value),
        .is_midi       (is_midi),
        .span          (span),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .ignored       (ignored)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Magnitude of a full-precision difference, zero-extended for scaling
    function automatic logic [63:0] magnitude(input logic signed [DIFF_W-1:0] d);
        logic [DIFF_W-1:0] m;
        m = d[DIFF_W-1] ? -d : d;
        return 64'(m);
    endfunction

    // Apply one event to the mirrored table and return whether the move is dropped
    function automatic bit takeover_verdict(input gate_event_t ev);
        int                      idx;
        logic signed [DIFF_W-1:0] d_new;
        logic signed [DIFF_W-1:0] d_prev;
        logic [63:0]             limit;
        logic [TIME_W-1:0]       elapsed;
        bit                      far_new;
        bit                      far_prev;
        bit                      same_side;
        bit                      drop;
        idx  = ev.ctl;
        drop = 1'b0;
        case (ev.op)
            FN_ENABLE:
            begin
                // keep an existing timestamp and previous value
                if (!armed[idx])
                begin
                    armed[idx]     = 1'b1;
                    last_pass[idx] = ev.stamp;
                end
                if (!held[idx])
                begin
                    held[idx]     = 1'b1;
                    held_val[idx] = ev.cur;
                end
            end
            FN_DISABLE:
                armed[idx] = 1'b0;
            FN_MOVE:
                if (armed[idx])
                begin
                    d_new     = ev.cur - ev.want;
                    d_prev    = '0;
                    if (held[idx])
                        d_prev = ev.cur - held_val[idx];
                    same_side = held[idx] && ((d_prev < 0 && d_new < 0) ||
                                              (d_prev > 0 && d_new > 0));
                    // compare |d| * 128 against three times the span, or 128 times 3.0 for MIDI
                    limit     = ev.midi ? (64'd3 << (FRAC_BITS + SCALE_SH))
                                        : 64'(ev.spn) * 3;
                    far_new   = (magnitude(d_new)  << SCALE_SH) > limit;
                    far_prev  = (magnitude(d_prev) << SCALE_SH) > limit;
                    elapsed   = ev.stamp - last_pass[idx];
                    drop      = far_new && far_prev && same_side &&
                                (elapsed > TIME_W'(hold_off));
                    if (!drop)
                        last_pass[idx] = ev.stamp;
                    held[idx]     = 1'b1;
                    held_val[idx] = ev.want;
                end
            default:
                ;
        endcase
        return drop;
    endfunction

    // Monitor: predict on each input transfer, check each result transfer.
    always @(posedge clk)
    begin : monitor_proc
        gate_event_t seen;
        bit          expected;
        in_xfer = rst_n && in_valid && !in_stall;
        if (in_xfer)
        begin
            seen.op    = func;
            seen.ctl   = control_id;
            seen.stamp = now_ms;
            seen.cur   = current_value;
            seen.want  = new_value;
            seen.midi  = is_midi;
            seen.spn   = span;
            verdict_q.push_back(takeover_verdict(seen));
            events_sent++;
            if (func == FN_MOVE)
                moves_sent++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("result with no event outstanding: ignored=%0b", ignored);
                fail_count++;
            end
            else
            begin
                expected = verdict_q.pop_front();
                verdicts_checked++;
                drops_seen += expected;
                if (ignored !== expected)
                begin
                    $error("ignored mismatch: expected %0b, actual %0b", expected, ignored);
                    fail_count++;
                end
            end
        end
    end

    // Driver: hold a stalled event, otherwise advance through bursts and gaps.
    always @(negedge clk)
    begin : driver_proc
        gate_event_t ev;
        if (rst_n && !(in_valid && !in_xfer))
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (event_q.size() > 0)
            begin
                ev = event_q.pop_front();
                in_valid      <= 1'b1;
                func          <= ev.op;
                control_id    <= ev.ctl;
                now_ms        <= ev.stamp;
                current_value <= ev.cur;
                new_value     <= ev.want;
                is_midi       <= ev.midi;
                span          <= ev.spn;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    // a third of bursts run straight into the next one
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: stall in runs of free flow, coin flips, heavy back-pressure
    // and a regular beat.
    always @(negedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = $urandom_range(8, 60);
        end
        stall_run--;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 1) == 0);
            2:       out_stall <= ($urandom_range(0, 9) != 0);
            default: out_stall <= (stall_run % 3 == 0);
        endcase
    end

    // Watchdog: give up once nothing has transferred for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $error("no transfer for %0d cycles, %0d results outstanding",
                   WATCHDOG_LIMIT, verdict_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic queue_event(input logic [FUNC_W-1:0] op, input logic [ID_W-1:0] ctl,
                               input logic [TIME_W-1:0] stamp,
                               input logic signed [VAL_W-1:0] cur,
                               input logic signed [VAL_W-1:0] want,
                               input logic midi, input logic [SPAN_W-1:0] spn);
        gate_event_t ev;
        ev.op    = op;
        ev.ctl   = ctl;
        ev.stamp = stamp;
        ev.cur   = cur;
        ev.want  = want;
        ev.midi  = midi;
        ev.spn   = spn;
        event_q.push_back(ev);
    endtask

    // Mostly well-formed takeover sequences on a small pool of controls: a
    // resting value, moves that drift to one side of it, and offsets placed on
    // and around the threshold; the rest is noise.
    task automatic add_random_events(input int count);
        gate_event_t       ev;
        int                pick;
        logic [TIME_W-1:0] step;
        logic [63:0]       thr;
        logic [63:0]       mag;
        for (int n = 0; n < count; n++)
        begin
            pick   = $urandom_range(0, 99);
            ev.ctl = ($urandom_range(0, 3) != 0) ? ID_W'($urandom_range(0, 5))
                                                 : ID_W'($urandom);
            if (pick < 10)
                ev.op = FN_ENABLE;
            else if (pick < 15)
                ev.op = FN_DISABLE;
            else if (pick < 18)
                ev.op = FN_SPARE;
            else
                ev.op = FN_MOVE;

            // time steps land below, on and above the hold-off, with rare big jumps
            case ($urandom_range(0, 9))
                0, 1:    step = $urandom_range(0, 3);
                2:       step = TIME_W'(hold_off) + $urandom_range(0, 1);
                3:       step = $urandom;
                default: step = $urandom_range(0, 2 * hold_off + 2);
            endcase
            sim_clock += step;
            ev.stamp = sim_clock;

            ev.midi = $urandom_range(0, 1);
            case ($urandom_range(0, 9))
                0:       ev.spn = '0;
                1:       ev.spn = '1;
                2:       ev.spn = SPAN_NOMINAL;
                3:       ev.spn = SPAN_W'({$urandom, $urandom});
                default: ev.spn = (SPAN_W'($urandom_range(1, 1000)) << FRAC_BITS) |
                                  SPAN_W'($urandom_range(0, 16'hFFFF));
            endcase

            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 4))
                    0:       anchor[ev.ctl] = VAL_MAX;
                    1:       anchor[ev.ctl] = VAL_MIN;
                    2:       anchor[ev.ctl] = VAL_W'({$urandom, $urandom});
                    default: anchor[ev.ctl] = VAL_W'(int'($urandom_range(0, 2000)) - 1000)
                                              << FRAC_BITS;
                endcase
            end
            if ($urandom_range(0, 9) == 0)
                rising[ev.ctl] = !rising[ev.ctl];
            ev.cur = anchor[ev.ctl];

            thr = ev.midi ? (64'd3 << FRAC_BITS) : 64'(ev.spn) * 3 / 128;
            case ($urandom_range(0, 9))
                0:       mag = 0;
                1:       mag = thr;
                2:       mag = thr + 1;
                3:       mag = (thr > 0) ? thr - 1 : 0;
                4:       mag = {$urandom, $urandom} % (thr + 1);
                default: mag = thr + 1 + {$urandom, $urandom} % (4 * thr + 1);
            endcase
            ev.want = rising[ev.ctl] ? ev.cur + VAL_W'(mag) : ev.cur - VAL_W'(mag);
            if ($urandom_range(0, 19) == 0)
                ev.want = VAL_W'({$urandom, $urandom});
            event_q.push_back(ev);
        end
    endtask

    // Block until every queued event has transferred and every verdict has come back
    task automatic wait_idle();
        do
            @(posedge clk);
        while (event_q.size() != 0 || in_valid || verdict_q.size() != 0);
    endtask

    task automatic write_hold_off(input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        hold_off = value;
        settings_run++;
    endtask

    initial
    begin : main_proc
        logic [CFG_W-1:0] settings [5];
        settings[0] = '0;
        settings[1] = '1;
        settings[2] = CFG_W'($urandom_range(2, 16'hFFFE));
        settings[3] = CFG_W'(1);
        settings[4] = OVERRIDE_RST;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        settings_run = 1;

        // Directed part, run at the reset hold-off of 50 ms.
        // Move on a control that was never enabled.
        queue_event(FN_MOVE,    0, T0,       0,        5 * UNIT,   1'b1, '0);
        queue_event(FN_ENABLE,  0, T0,       0,        0,          1'b1, '0);
        // Second enable must keep both the timestamp and the previous value.
        queue_event(FN_ENABLE,  0, T0 + 40,  7 * UNIT, 0,          1'b1, '0);
        queue_event(FN_MOVE,    0, T0 + 60,  0,        10 * UNIT,  1'b1, '0);
        // Far jump on the same side after the clock wraps: drop it.
        queue_event(FN_MOVE,    0, T0 + 120, 0,        20 * UNIT,  1'b1, '0);
        // Exactly on the MIDI threshold is not far.
        queue_event(FN_MOVE,    0, T0 + 130, 0,        3 * UNIT,   1'b1, '0);
        queue_event(FN_MOVE,    0, T0 + 300, 0,        30 * UNIT,  1'b1, '0);
        // Inside the hold-off, then exactly on it, then one past it.
        queue_event(FN_MOVE,    0, T0 + 340, 0,        40 * UNIT,  1'b1, '0);
        queue_event(FN_MOVE,    0, T0 + 390, 0,        50 * UNIT,  1'b1, '0);
        queue_event(FN_MOVE,    0, T0 + 441, 0,        60 * UNIT,  1'b1, '0);
        // Equal values sit on neither side.
        queue_event(FN_MOVE,    0, T0 + 500, 0,        0,          1'b1, '0);
        queue_event(FN_DISABLE, 0, T0 + 600, 0,        0,          1'b1, '0);
        queue_event(FN_MOVE,    0, T0 + 700, 0,        90 * UNIT,  1'b1, '0);
        queue_event(FN_ENABLE,  0, T0 + 800, 5 * UNIT, 0,          1'b1, '0);
        // Drop on the other side: the new value below the current one.
        queue_event(FN_MOVE,    0, T0 + 900, 20 * UNIT, -10 * UNIT, 1'b1, '0);
        // Value and span extremes on the top entry.
        queue_event(FN_ENABLE,  63, 32'h0000_0000, VAL_MAX, VAL_MAX,     1'b0, '1);
        queue_event(FN_MOVE,    63, 32'hFFFF_FFFF, VAL_MAX, VAL_MIN,     1'b0, '0);
        queue_event(FN_MOVE,    63, 32'h7FFF_FFFF, VAL_MAX, VAL_MIN + 1, 1'b0, '1);
        queue_event(FN_MOVE,    63, 32'h8000_0000, VAL_MIN, VAL_MAX,     1'b0, SPAN_NOMINAL);
        queue_event(FN_SPARE,   5,  '1,            VAL_MAX, VAL_MIN,     1'b1, '1);
        // Span of 128 gives a non-MIDI threshold of exactly 3 LSBs.
        queue_event(FN_ENABLE,  42, 32'd1000, 0, 0, 1'b0, SPAN_W'(128));
        queue_event(FN_MOVE,    42, 32'd2000, 0, 4, 1'b0, SPAN_W'(128));
        queue_event(FN_MOVE,    42, 32'd3000, 0, 3, 1'b0, SPAN_W'(128));
        queue_event(FN_MOVE,    42, 32'd4000, 0, 5, 1'b0, SPAN_W'(128));
        queue_event(FN_MOVE,    42, 32'd5000, 0, 6, 1'b0, SPAN_W'(128));
        wait_idle();

        // Random part: sweep the hold-off through its extremes, pausing the
        // sender at each change until every verdict is home.
        foreach (settings[k])
        begin
            write_hold_off(settings[k]);
            add_random_events(PHASE_EVENTS);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (verdict_q.size() != 0)
        begin
            $error("%0d verdicts never arrived", verdict_q.size());
            fail_count++;
        end

        $display("Ran %0d events (%0d moves) across %0d hold-off settings.",
                 events_sent, moves_sent, settings_run);
        $display("Checked %0d verdicts, %0d of them dropped moves.",
                 verdicts_checked, drops_seen);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
